### hdl/complex_trace_peak_phase_unit_defines.svh
// ----------------------------------------------------------------------------
// Complex trace peak phase unit assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_TRACE_PEAK_PHASE_UNIT_DEFINES_SVH
`define COMPLEX_TRACE_PEAK_PHASE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CTPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctpp: same-cycle check failed");
`define CTPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctpp: next-cycle check failed");
`else
`define CTPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTPP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/ctpp_pkg.sv
// ----------------------------------------------------------------------------
// Complex trace peak phase package
// Widths, payload, job and state types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ctpp_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_TRACE    = 16384;
  localparam int PHASE_BITS   = 16;
  localparam int IDX_BITS     = $clog2(MAX_TRACE);
  localparam int LEN_BITS     = 15;
  localparam int SQ_BITS      = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS    = SAMPLE_BITS;
  localparam int REM_BITS     = ROOT_BITS + 3;
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_SCALE = 28;
  localparam int CW           = SAMPLE_BITS + CORDIC_SCALE + 4;
  localparam int STEP_BITS    = 5;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = QPTR_BITS + 1;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = LEN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_DC_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRACE_LENGTH = 1'd1;
  localparam logic [LEN_BITS-1:0]     TRACE_LEN_RESET  = LEN_BITS'(256);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
    logic signed [SAMPLE_BITS-1:0] dc_real;
    logic signed [SAMPLE_BITS-1:0] dc_imag;
  } ctpp_in_t;

  typedef struct packed {
    logic        [SAMPLE_BITS-1:0] peak_magnitude;
    logic signed [PHASE_BITS-1:0]  peak_phase;
    logic signed [SAMPLE_BITS-1:0] peak_real;
    logic signed [SAMPLE_BITS-1:0] peak_imag;
    logic        [IDX_BITS-1:0]    peak_index;
  } ctpp_out_t;

  typedef struct packed {
    logic        [SQ_BITS-1:0]     square;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic        [IDX_BITS-1:0]    idx;
  } peak_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_t;

  function automatic logic [31:0] atan_lut(input logic [STEP_BITS-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

### hdl/ctpp_front.sv
// ----------------------------------------------------------------------------
// Complex trace peak phase front end
// Accepts samples, optionally removes DC, squares, tracks the peak and queues one job
// per finished trace.
// ----------------------------------------------------------------------------
module ctpp_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ctpp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ctpp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ctpp_pkg::ctpp_in_t                   in_data,
  input  logic [ctpp_pkg::QCNT_BITS-1:0]       q_count,
  output logic                                 push,
  output ctpp_pkg::peak_job_t                  push_data
);
  import ctpp_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          dc_enable_r;
  logic [LEN_BITS-1:0]           trace_length_r;
  logic [IDX_BITS-1:0]           counter_r;

  logic                          s1_valid_r, s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_re_r, s1_im_r;
  logic [IDX_BITS-1:0]           s1_idx_r;

  logic                          s2_valid_r, s2_last_r;
  logic signed [SAMPLE_BITS-1:0] s2_re_r, s2_im_r;
  logic [IDX_BITS-1:0]           s2_idx_r;
  logic [SQ_BITS-1:0]            s2_rr_r, s2_ii_r;

  logic [SQ_BITS-1:0]            best_sq_r;
  logic signed [SAMPLE_BITS-1:0] best_re_r, best_im_r;
  logic [IDX_BITS-1:0]           best_idx_r;

  logic                          accept;
  logic [LEN_BITS-1:0]           len_eff;
  logic                          last;
  logic signed [SAMPLE_BITS:0]   diff_re, diff_im;
  logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
  logic [QCNT_BITS:0]            reserved;
  logic [SQ_BITS-1:0]            sq;
  logic                          take;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAMPLE_BITS:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v[SAMPLE_BITS] != v[SAMPLE_BITS-1]) begin
      r = v[SAMPLE_BITS] ? S_MIN : S_MAX;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_enable_r    <= 1'b0;
      trace_length_r <= TRACE_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DC_ENABLE:    dc_enable_r    <= cfg_wdata[0];
        REG_TRACE_LENGTH: trace_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    reserved = (QCNT_BITS+1)'(q_count) + (QCNT_BITS+1)'(s1_valid_r & s1_last_r)
             + (QCNT_BITS+1)'(s2_valid_r & s2_last_r);
    in_stall = (reserved >= (QCNT_BITS+1)'(QUEUE_DEPTH));
    accept   = in_valid && !in_stall;

    if (trace_length_r == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (trace_length_r > LEN_BITS'(MAX_TRACE)) begin
      len_eff = LEN_BITS'(MAX_TRACE);
    end else begin
      len_eff = trace_length_r;
    end
    last = ((LEN_BITS'(counter_r) + LEN_BITS'(1)) >= len_eff);

    diff_re = (SAMPLE_BITS+1)'(in_data.sample_real) - (SAMPLE_BITS+1)'(in_data.dc_real);
    diff_im = (SAMPLE_BITS+1)'(in_data.sample_imag) - (SAMPLE_BITS+1)'(in_data.dc_imag);
    sat_re  = dc_enable_r ? sat_sample(diff_re) : in_data.sample_real;
    sat_im  = dc_enable_r ? sat_sample(diff_im) : in_data.sample_imag;

    sq   = s2_rr_r + s2_ii_r;
    take = (sq >= best_sq_r);

    push             = s2_valid_r && s2_last_r;
    push_data.square = take ? sq : best_sq_r;
    push_data.re     = take ? s2_re_r : best_re_r;
    push_data.im     = take ? s2_im_r : best_im_r;
    push_data.idx    = take ? s2_idx_r : best_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      best_sq_r  <= '0;
      best_re_r  <= '0;
      best_im_r  <= '0;
      best_idx_r <= '0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      if (accept) begin
        counter_r <= last ? '0 : counter_r + IDX_BITS'(1);
      end
      if (s2_valid_r) begin
        if (s2_last_r) begin
          best_sq_r  <= '0;
          best_re_r  <= '0;
          best_im_r  <= '0;
          best_idx_r <= '0;
        end else if (take) begin
          best_sq_r  <= sq;
          best_re_r  <= s2_re_r;
          best_im_r  <= s2_im_r;
          best_idx_r <= s2_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_re_r   <= sat_re;
      s1_im_r   <= sat_im;
      s1_idx_r  <= counter_r;
      s1_last_r <= last;
    end
    s2_re_r   <= s1_re_r;
    s2_im_r   <= s1_im_r;
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    s2_rr_r   <= s1_re_r * s1_re_r;
    s2_ii_r   <= s1_im_r * s1_im_r;
  end

endmodule

### hdl/ctpp_queue.sv
// ----------------------------------------------------------------------------
// Complex trace peak phase job queue
// Short FIFO of finished-trace jobs between front end and back end.
// ----------------------------------------------------------------------------
module ctpp_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  ctpp_pkg::peak_job_t               push_data,
  input  logic                              pop,
  output logic                              q_valid,
  output ctpp_pkg::peak_job_t               pop_data,
  output logic [ctpp_pkg::QCNT_BITS-1:0]    q_count
);
  import ctpp_pkg::*;

  peak_job_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;

  assign q_valid  = (count_r != '0);
  assign q_count  = count_r;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_BITS'(1);
        2'b01:   count_r <= count_r - QCNT_BITS'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hdl/ctpp_back.sv
// ----------------------------------------------------------------------------
// Complex trace peak phase back end
// Iterative rounded square root and CORDIC vectoring per queued job.
// ----------------------------------------------------------------------------
module ctpp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  ctpp_pkg::peak_job_t     pop_data,
  output logic                    pop,
  output logic                    back_busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ctpp_pkg::ctpp_out_t     out_data
);
  import ctpp_pkg::*;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);
  localparam logic [31:0] ROUND_HALF = 32'(1) << (31 - PHASE_BITS);

  back_state_t                   state_r, state_nxt;
  logic [STEP_BITS-1:0]          step_r;
  logic [SQ_BITS-1:0]            rad_r;
  logic [ROOT_BITS-1:0]          root_r;
  logic [REM_BITS-1:0]           rem_r;
  logic signed [CW-1:0]          x_r, y_r;
  logic [31:0]                   z_r;
  logic                          zero_r;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r;
  logic [IDX_BITS-1:0]           idx_r;
  logic                          out_valid_r;
  ctpp_out_t                     out_r;

  logic                          out_free, load_out;
  logic signed [CW-1:0]          x0, y0, xl, yl, dx, dy;
  logic [31:0]                   zl, ang, z_rnd;
  logic [REM_BITS-1:0]           rem_sh, trial;
  logic [SAMPLE_BITS-1:0]        mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign back_busy = (state_r != BK_IDLE);

  always_comb begin
    x0 = CW'(pop_data.re) <<< CORDIC_SCALE;
    y0 = CW'(pop_data.im) <<< CORDIC_SCALE;
    if (pop_data.re < 0) begin
      if (pop_data.im >= 0) begin
        xl = y0;
        yl = -x0;
        zl = 32'h40000000;
      end else begin
        xl = -y0;
        yl = x0;
        zl = 32'hC0000000;
      end
    end else begin
      xl = x0;
      yl = y0;
      zl = 32'h0;
    end
    dx  = y_r >>> step_r;
    dy  = x_r >>> step_r;
    ang = atan_lut(step_r);

    rem_sh = {rem_r[REM_BITS-3:0], rad_r[SQ_BITS-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};

    mag   = root_r + SAMPLE_BITS'(rem_r > REM_BITS'(root_r));
    z_rnd = z_r + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (pop) begin
      step_r <= '0;
    end else if (state_r == BK_RUN) begin
      step_r <= step_r + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rad_r  <= pop_data.square;
      root_r <= '0;
      rem_r  <= '0;
      x_r    <= xl;
      y_r    <= yl;
      z_r    <= zl;
      zero_r <= (pop_data.re == 0) && (pop_data.im == 0);
      re_r   <= pop_data.re;
      im_r   <= pop_data.im;
      idx_r  <= pop_data.idx;
    end else if (state_r == BK_RUN) begin
      if (step_r < STEP_BITS'(ROOT_BITS)) begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_BITS-2:0], 1'b0};
        end
      end
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.peak_magnitude <= mag;
      out_r.peak_phase     <= zero_r ? '0 : z_rnd[31 -: PHASE_BITS];
      out_r.peak_real      <= re_r;
      out_r.peak_imag      <= im_r;
      out_r.peak_index     <= idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/complex_trace_peak_phase_unit.sv
// ----------------------------------------------------------------------------
// Complex trace peak phase unit
// Peak magnitude, phase, value and position of each complex sample trace.
// ----------------------------------------------------------------------------
// Port group  Direction  Beat
// in_*        in         one complex sample plus DC offsets (ctpp_in_t)
// out_*       out        one peak report per trace (ctpp_out_t)
// cfg_*       in         register write: 0 dc_enable, 1 trace_length
//
// Samples go in one per cycle unless stalled; the peak search has two stages.
// Each finished trace queues a job; the back end runs it as one load, 31
// CORDIC steps with the 24-step square root alongside and one output load.
// in_stall rises only when four jobs are queued or in the front pipeline.
// out_stall holds the report register; the back end then waits in its hold
// state. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "complex_trace_peak_phase_unit_defines.svh"

module complex_trace_peak_phase_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ctpp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ctpp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ctpp_pkg::ctpp_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ctpp_pkg::ctpp_out_t                  out_data
);
  import ctpp_pkg::*;

  logic                  push, pop, q_valid, back_busy;
  peak_job_t             push_data, pop_data;
  logic [QCNT_BITS-1:0]  q_count;

  ctpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ctpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data),
    .q_count   (q_count)
  );

  ctpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .back_busy (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `CTPP_ASSERT_IMP(a_push_room, clk, rst_n, push, (q_count < QCNT_BITS'(QUEUE_DEPTH)) || pop)
  `CTPP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, q_count != '0)
  `CTPP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, q_count <= QCNT_BITS'(QUEUE_DEPTH))
  `CTPP_ASSERT_NXT(a_pop_busy, clk, rst_n, pop, back_busy)

endmodule
